### src/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg: shared types, constants and fixed-point helpers
// Types and saturation helpers used by the ADRC observer/controller datapath.
// ----------------------------------------------------------------------------
package adrc_pkg;

  localparam int unsigned NUM_GAINS = 8;
  localparam int unsigned GAIN_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [GAIN_IDX_W-1:0] REG_REF_GAIN        = 3'd0;
  localparam logic [GAIN_IDX_W-1:0] REG_RATE_GAIN       = 3'd1;
  localparam logic [GAIN_IDX_W-1:0] REG_ERROR_GAIN      = 3'd2;
  localparam logic [GAIN_IDX_W-1:0] REG_DISTURBANCE_GAIN = 3'd3;
  localparam logic [GAIN_IDX_W-1:0] REG_OBS_DRIVE_GAIN0 = 3'd4;
  localparam logic [GAIN_IDX_W-1:0] REG_OBS_ERROR_GAIN0 = 3'd5;
  localparam logic [GAIN_IDX_W-1:0] REG_OBS_DRIVE_GAIN1 = 3'd6;
  localparam logic [GAIN_IDX_W-1:0] REG_OBS_ERROR_GAIN1 = 3'd7;

  localparam logic [63:0] GAIN_RESET [NUM_GAINS] = '{
    64'd274877906944000000, 64'd1099511627776000, 64'd184348001000000000,
    64'd4000111760849088, 64'd549756, 64'd507315947121, 64'd1099511628,
    64'd76025333954433
  };

  localparam logic [63:0] Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  // dead zone in Q31.32: 0.4 and 0.2
  localparam logic signed [63:0] DZ_THRESHOLD     = 64'sd1717986918;
  localparam logic signed [63:0] DZ_THRESHOLD_NEG = -64'sd1717986918;
  localparam logic [63:0]        DZ_OFFSET        = 64'd858993459;

  // sum width: four 64-bit terms add without overflow
  localparam int unsigned SUM_W = 68;

  // partial product of the 64x64 split into 32-bit halves
  typedef enum logic [1:0] {PP_HH, PP_HL, PP_LH, PP_LL} pp_sel_t;

  typedef struct packed {
    logic    issue;
    pp_sel_t sel;
  } mac_ctl_t;

  typedef struct packed {
    logic                  en;
    logic [GAIN_IDX_W-1:0] idx;
    logic [63:0]           data;
  } cfg_wr_t;

  typedef enum logic [1:0] {X_RERR, X_Z1, X_ERR, X_DRIVE} xsel_t;
  typedef enum logic [2:0] {D_DRV_ADD, D_DRV_SUB, D_Z0, D_Z1, D_Z2} dest_t;

  typedef struct packed {
    logic [GAIN_IDX_W-1:0] gain_idx;
    xsel_t                 xsel;
    dest_t                 dest;
  } prod_op_t;

  // product schedule; the drive terms come first, drive products last
  function automatic prod_op_t prod_op(input logic [2:0] slot);
    prod_op_t op;
    case (slot)
      3'd0:    op = '{REG_REF_GAIN,         X_RERR,  D_DRV_ADD};
      3'd1:    op = '{REG_RATE_GAIN,        X_Z1,    D_DRV_SUB};
      3'd2:    op = '{REG_ERROR_GAIN,       X_ERR,   D_DRV_SUB};
      3'd3:    op = '{REG_DISTURBANCE_GAIN, X_ERR,   D_Z2};
      3'd4:    op = '{REG_OBS_ERROR_GAIN0,  X_ERR,   D_Z0};
      3'd5:    op = '{REG_OBS_ERROR_GAIN1,  X_ERR,   D_Z1};
      3'd6:    op = '{REG_OBS_DRIVE_GAIN0,  X_DRIVE, D_Z0};
      default: op = '{REG_OBS_DRIVE_GAIN1,  X_DRIVE, D_Z1};
    endcase
    return op;
  endfunction

  function automatic logic [63:0] sat64(input logic [SUM_W-1:0] v);
    logic [63:0] r;
    if (v[SUM_W-1:63] == {(SUM_W-63){v[63]}}) r = v[63:0];
    else r = v[SUM_W-1] ? Q_MIN : Q_MAX;
    return r;
  endfunction

  // Q.72 product floored to Q31.32 and saturated
  function automatic logic [63:0] term_sat(input logic [127:0] acc);
    logic [63:0] r;
    if (acc[127:103] == {25{acc[103]}}) r = acc[103:40];
    else r = acc[127] ? Q_MIN : Q_MAX;
    return r;
  endfunction

  function automatic logic [31:0] to_q16(input logic [63:0] x);
    logic [31:0] r;
    if (x[63:47] == {17{x[47]}}) r = x[47:16];
    else r = x[63] ? Q16_MIN : Q16_MAX;
    return r;
  endfunction

  function automatic logic [63:0] widen_q16(input logic [31:0] v);
    return {{16{v[31]}}, v, 16'h0000};
  endfunction

  function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    logic [63:0] r;
    d = {a[63], a} - {b[63], b};
    if (d[64] == d[63]) r = d[63:0];
    else r = d[64] ? Q_MIN : Q_MAX;
    return r;
  endfunction

  function automatic logic [63:0] dead_zone(input logic [63:0] drive);
    logic [63:0] r;
    if ($signed(drive) > DZ_THRESHOLD) r = drive - DZ_OFFSET;
    else if ($signed(drive) < DZ_THRESHOLD_NEG) r = drive + DZ_OFFSET;
    else r = '0;
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sext_sum(input logic [63:0] v);
    return {{(SUM_W-64){v[63]}}, v};
  endfunction

endpackage

### src/adrc_gain_regs.sv
// ----------------------------------------------------------------------------
// adrc_gain_regs: gain register file
// Eight signed Q23.40 gains, one write port, one read port for the sequencer.
// ----------------------------------------------------------------------------
module adrc_gain_regs
  import adrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_wr_t               wr,
  input  logic [GAIN_IDX_W-1:0] rd_idx,
  output logic [63:0]           rd_data
);

  logic [63:0] gain_r [NUM_GAINS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_GAINS; i++) gain_r[i] <= GAIN_RESET[i];
    end else if (wr.en) begin
      gain_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = gain_r[rd_idx];

endmodule

### src/adrc_mac.sv
// ----------------------------------------------------------------------------
// adrc_mac: shared multiply-accumulate unit
// One 33x33 signed multiplier builds a 64x64 product from four partial
// products into a 128-bit accumulator and presents the floored Q31.32 term.
// ----------------------------------------------------------------------------
module adrc_mac
  import adrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mac_ctl_t    ctl,
  input  logic [63:0] gain,
  input  logic [63:0] x,
  output logic [63:0] term
);

  logic signed [32:0]  op_a;
  logic signed [32:0]  op_b;
  logic signed [65:0]  prod;
  logic        [65:0]  prod_r;
  pp_sel_t             sel_r;
  logic                vld_r;
  logic        [127:0] prod_ext;
  logic        [127:0] aligned;
  logic        [127:0] acc_r;

  // upper halves carry the sign, lower halves are unsigned
  always_comb begin
    case (ctl.sel)
      PP_HH: begin
        op_a = {gain[63], gain[63:32]};
        op_b = {x[63], x[63:32]};
      end
      PP_HL: begin
        op_a = {gain[63], gain[63:32]};
        op_b = {1'b0, x[31:0]};
      end
      PP_LH: begin
        op_a = {1'b0, gain[31:0]};
        op_b = {x[63], x[63:32]};
      end
      default: begin
        op_a = {1'b0, gain[31:0]};
        op_b = {1'b0, x[31:0]};
      end
    endcase
    prod = op_a * op_b;
  end

  always_comb begin
    prod_ext = {{62{prod_r[65]}}, prod_r};
    case (sel_r)
      PP_HH:   aligned = prod_ext << 64;
      PP_HL:   aligned = prod_ext << 32;
      PP_LH:   aligned = prod_ext << 32;
      default: aligned = prod_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.issue;
    end
    if (ctl.issue) begin
      prod_r <= prod;
      sel_r  <= ctl.sel;
    end
    // the high partial opens each product and reloads the accumulator
    if (vld_r) begin
      acc_r <= (sel_r == PP_HH) ? aligned : acc_r + aligned;
    end
  end

  assign term = term_sat(acc_r);

endmodule

### src/adrc_observer_controller.sv
// ----------------------------------------------------------------------------
// adrc_observer_controller: linear ADRC extended state observer and drive law
// Per tick: observer error, raw drive, dead-zone control and estimate update.
// ----------------------------------------------------------------------------
//  channel | direction | payload (low bits first)
//  in_     | slave     | feedback[31:0], reference[63:32]
//  out_    | master    | control, estimate_pos, estimate_rate, estimate_dist
//  cfg_    | slave     | cfg_index (gain 0..7, higher ignored), cfg_data
//
//  Each item runs eight 64x64 gain products, each four partial products on
//  the one shared 33x33 multiplier, drained through the product and
//  accumulator registers. The drive is saturated before the two drive
//  products; the estimates are committed last, then in_tready returns.
//  Synchronous reset restores the default gains and clears the estimates.
//  A stalled result holds in the output register; the next word is accepted
//  while it waits, and commit waits only if the register is still full.
// ----------------------------------------------------------------------------
module adrc_observer_controller
  import adrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // feedback[31:0], reference[63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // control[31:0], estimate_pos[63:32],
                                   // estimate_rate[95:64], estimate_dist[127:96]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DRIVE, S_FINISH} state_t;

  localparam logic [2:0] STEP_LAST = 3'd5;
  localparam logic [2:0] SLOT_PRE_DRIVE = 3'd5;
  localparam logic [2:0] SLOT_LAST = 3'd7;

  state_t           state_r, state_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [63:0]      err_r, err_nxt;
  logic [63:0]      rerr_r, rerr_nxt;
  logic [63:0]      z0_r, z0_nxt;
  logic [63:0]      z1_r, z1_nxt;
  logic [63:0]      z2_r, z2_nxt;
  logic [SUM_W-1:0] sum_drv_r, sum_drv_nxt;
  logic [SUM_W-1:0] sum_z0_r, sum_z0_nxt;
  logic [SUM_W-1:0] sum_z1_r, sum_z1_nxt;
  logic [63:0]      sum_z2_r, sum_z2_nxt;
  logic [63:0]      drive_r, drive_nxt;
  logic [127:0]     out_tdata_r, out_tdata_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  cfg_wr_t          cfg_wr;
  mac_ctl_t         mac_ctl;
  prod_op_t         op;
  logic [63:0]      gain;
  logic [63:0]      x_op;
  logic [63:0]      term;
  logic [63:0]      fb_q;
  logic [63:0]      rf_q;
  logic [63:0]      z0_new;
  logic [63:0]      z1_new;

  assign cfg_ready  = 1'b1;
  assign cfg_wr.en  = cfg_valid && (cfg_index < 8'(NUM_GAINS));
  assign cfg_wr.idx = cfg_index[GAIN_IDX_W-1:0];
  assign cfg_wr.data = cfg_data;

  assign op = prod_op(slot_r);

  adrc_gain_regs u_gains (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cfg_wr),
    .rd_idx  (op.gain_idx),
    .rd_data (gain)
  );

  always_comb begin
    case (op.xsel)
      X_RERR:  x_op = rerr_r;
      X_Z1:    x_op = z1_r;
      X_ERR:   x_op = err_r;
      default: x_op = drive_r;
    endcase
  end

  assign mac_ctl.issue = (state_r == S_MUL) && (step_r < 3'd4);
  assign mac_ctl.sel   = pp_sel_t'(step_r[1:0]);

  adrc_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .gain (gain),
    .x    (x_op),
    .term (term)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign fb_q   = widen_q16(in_tdata[31:0]);
  assign rf_q   = widen_q16(in_tdata[63:32]);
  assign z0_new = sat64(sum_z0_r);
  assign z1_new = sat64(sum_z1_r);

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    step_nxt       = step_r;
    err_nxt        = err_r;
    rerr_nxt       = rerr_r;
    z0_nxt         = z0_r;
    z1_nxt         = z1_r;
    z2_nxt         = z2_r;
    sum_drv_nxt    = sum_drv_r;
    sum_z0_nxt     = sum_z0_r;
    sum_z1_nxt     = sum_z1_r;
    sum_z2_nxt     = sum_z2_r;
    drive_nxt      = drive_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          err_nxt     = sub_sat(fb_q, z0_r);
          rerr_nxt    = sub_sat(rf_q, z0_r);
          sum_drv_nxt = '0 - sext_sum(z2_r);
          sum_z0_nxt  = '0;
          sum_z1_nxt  = '0;
          slot_nxt    = '0;
          step_nxt    = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        if (step_r == STEP_LAST) begin
          case (op.dest)
            D_DRV_ADD: sum_drv_nxt = sum_drv_r + sext_sum(term);
            D_DRV_SUB: sum_drv_nxt = sum_drv_r - sext_sum(term);
            D_Z0:      sum_z0_nxt  = sum_z0_r + sext_sum(term);
            D_Z1:      sum_z1_nxt  = sum_z1_r + sext_sum(term);
            default:   sum_z2_nxt  = term;
          endcase
          step_nxt = '0;
          slot_nxt = slot_r + 3'd1;
          if (slot_r == SLOT_PRE_DRIVE) state_nxt = S_DRIVE;
          else if (slot_r == SLOT_LAST) state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_DRIVE: begin
        drive_nxt = sat64(sum_drv_r);
        state_nxt = S_MUL;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          z0_nxt         = z0_new;
          z1_nxt         = z1_new;
          z2_nxt         = sum_z2_r;
          out_tdata_nxt  = {to_q16(sum_z2_r), to_q16(z1_new), to_q16(z0_new),
                            to_q16(dead_zone(drive_r))};
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      slot_r       <= '0;
      step_r       <= '0;
      z0_r         <= '0;
      z1_r         <= '0;
      z2_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      slot_r       <= slot_nxt;
      step_r       <= step_nxt;
      z0_r         <= z0_nxt;
      z1_r         <= z1_nxt;
      z2_r         <= z2_nxt;
    end
    err_r       <= err_nxt;
    rerr_r      <= rerr_nxt;
    sum_drv_r   <= sum_drv_nxt;
    sum_z0_r    <= sum_z0_nxt;
    sum_z1_r    <= sum_z1_nxt;
    sum_z2_r    <= sum_z2_nxt;
    drive_r     <= drive_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

### src/adrc_checker.sv
// ----------------------------------------------------------------------------
// adrc_checker: port-level checks for the ADRC observer/controller
// Watches the stream handshakes of the top level over time.
// ----------------------------------------------------------------------------
module adrc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped under stall");

  // one word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in work");

  // a result cannot appear in the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // a new result comes with the block ready again
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result issued while still busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind adrc_observer_controller adrc_checker u_adrc_checker (.*);

### dv/adrc_observer_controller_test.sv
// ----------------------------------------------------------------------------
// adrc_observer_controller_test: self-checking bench for the ADRC observer
// Walks a short table of directed ticks and gain writes, then runs random
// phases of ticks under changing gains and handshake idling. Every result word
// is compared per field with a bit-exact fixed-point predictor or a typed value.
// ----------------------------------------------------------------------------
module adrc_observer_controller_test;
  import adrc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int END_SETTLE      = 60;
  localparam int PHASES          = 12;
  localparam int TICKS_PER_PHASE = 158;

  localparam logic signed [63:0] SAT_HI         = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_LO         = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] DEADBAND       = 64'sd1717986918;
  localparam logic signed [63:0] DEADBAND_SHIFT = 64'sd858993459;

  localparam logic [31:0] IN_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] IN_MIN  = 32'h8000_0000;
  localparam logic [31:0] IN_ONE  = 32'h0001_0000;
  localparam logic [31:0] IN_MONE = 32'hFFFF_0000;

  localparam logic [63:0] GAIN_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] GAIN_BOTTOM = 64'h8000_0000_0000_0000;
  localparam logic [63:0] GAIN_UNITY  = 64'd1 << 40;
  // with a reference of +-1.0 these put the drive exactly on, or one lsb past, 0.4
  localparam logic [63:0] GAIN_AT_DB   = 64'd1717986918 << 8;
  localparam logic [63:0] GAIN_PAST_DB = 64'd1717986919 << 8;

  localparam logic [7:0] IDX_UNMAPPED_LO = 8'(NUM_GAINS);
  localparam logic [7:0] IDX_UNMAPPED_HI = 8'hFF;

  typedef enum logic {ROW_TICK, ROW_GAIN} row_kind_t;
  typedef enum int {GAINS_DEFAULT, GAINS_MODEST, GAINS_EXTREME, GAINS_WILD, GAINS_MIXED}
    gain_style_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [7:0]   idx;
    logic [63:0]  gain;
    logic [31:0]  fb;
    logic [31:0]  rf;
    logic         typed;
    logic [127:0] want;
  } stim_row_t;

  localparam int N_ROWS = 37;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ROW_TICK, 8'd0, 64'd0, 32'd0, 32'd0, 1'b1, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MAX, IN_MAX, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MIN, IN_MIN, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MAX, IN_MIN, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MIN, IN_MAX, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_ONE, IN_MONE, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_REF_GAIN), GAIN_AT_DB, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_RATE_GAIN), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_ERROR_GAIN), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_DISTURBANCE_GAIN), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_DRIVE_GAIN0), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_ERROR_GAIN0), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_DRIVE_GAIN1), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_ERROR_GAIN1), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    // flush the old estimates, then sit exactly on the dead-zone edges
    '{ROW_TICK, 8'd0, 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MAX, IN_ONE, 1'b1, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MIN, IN_MONE, 1'b1, 128'd0},
    '{ROW_GAIN, 8'(REG_REF_GAIN), GAIN_PAST_DB, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, 32'd0, IN_ONE, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, 32'd0, IN_MONE, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_REF_GAIN), 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MAX, IN_MIN, 1'b1, 128'd0},
    '{ROW_GAIN, 8'(REG_REF_GAIN), GAIN_TOP, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_RATE_GAIN), GAIN_BOTTOM, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_ERROR_GAIN), GAIN_TOP, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_DISTURBANCE_GAIN), GAIN_BOTTOM, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_DRIVE_GAIN0), GAIN_TOP, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_ERROR_GAIN0), GAIN_BOTTOM, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_DRIVE_GAIN1), GAIN_BOTTOM, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, 8'(REG_OBS_ERROR_GAIN1), GAIN_TOP, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MAX, IN_MIN, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MIN, IN_MAX, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_ONE, IN_ONE, 1'b0, 128'd0},
    // writes past the last gain must leave every gain alone
    '{ROW_GAIN, IDX_UNMAPPED_HI, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_GAIN, IDX_UNMAPPED_LO, 64'd0, 32'd0, 32'd0, 1'b0, 128'd0},
    '{ROW_TICK, 8'd0, 64'd0, IN_MAX, IN_MAX, 1'b0, 128'd0}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  logic signed [63:0] gain_q [NUM_GAINS];
  logic signed [63:0] est [3];
  logic [127:0]       pending_outputs [$];
  logic [31:0]        last_pos;
  logic [31:0]        last_rf;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 fail_count;
  int                 words_checked;
  int                 idle_cycles;
  string              field_label [4] = '{"control", "estimate_pos", "estimate_rate",
                                          "estimate_dist"};

  adrc_observer_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [63:0] sat_q32(input logic signed [127:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v[63:0];
  endfunction

  // Q23.40 gain times Q31.32 value, floored back to Q31.32
  function automatic logic signed [63:0] gain_term(input logic signed [63:0] g,
                                                   input logic signed [63:0] x);
    logic signed [127:0] gw, xw, p;
    gw = g;
    xw = x;
    p = gw * xw;
    p = p >>> 40;
    return sat_q32(p);
  endfunction

  function automatic logic [31:0] q32_to_q16(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = x >>> 16;
    if (s > 64'sd2147483647) return IN_MAX;
    if (s < -64'sd2147483648) return IN_MIN;
    return s[31:0];
  endfunction

  // one control tick; returns {dist, rate, pos, control} and updates est[]
  function automatic logic [127:0] advance_observer(input logic [31:0] fb_in,
                                                    input logic [31:0] rf_in);
    logic signed [63:0]  fb, rf, err, rerr, drive, ctl;
    logic signed [127:0] acc;
    fb = {{16{fb_in[31]}}, fb_in, 16'h0000};
    rf = {{16{rf_in[31]}}, rf_in, 16'h0000};
    acc = fb;
    acc = acc - est[0];
    err = sat_q32(acc);
    acc = rf;
    acc = acc - est[0];
    rerr = sat_q32(acc);

    acc = gain_term(gain_q[REG_REF_GAIN], rerr);
    acc = acc - gain_term(gain_q[REG_RATE_GAIN], est[1]);
    acc = acc - est[2];
    acc = acc - gain_term(gain_q[REG_ERROR_GAIN], err);
    drive = sat_q32(acc);

    if (drive > DEADBAND) ctl = drive - DEADBAND_SHIFT;
    else if (drive < -DEADBAND) ctl = drive + DEADBAND_SHIFT;
    else ctl = '0;

    // estimates follow the raw drive, not the dead-zone output
    acc = gain_term(gain_q[REG_OBS_DRIVE_GAIN0], drive);
    acc = acc + gain_term(gain_q[REG_OBS_ERROR_GAIN0], err);
    est[0] = sat_q32(acc);
    acc = gain_term(gain_q[REG_OBS_DRIVE_GAIN1], drive);
    acc = acc + gain_term(gain_q[REG_OBS_ERROR_GAIN1], err);
    est[1] = sat_q32(acc);
    est[2] = gain_term(gain_q[REG_DISTURBANCE_GAIN], err);

    return {q32_to_q16(est[2]), q32_to_q16(est[1]), q32_to_q16(est[0]), q32_to_q16(ctl)};
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [63:0] draw_gain(input int idx, input gain_style_t style);
    gain_style_t s;
    logic [63:0] v;
    s = style;
    if (s == GAINS_MIXED) s = gain_style_t'($urandom_range(GAINS_WILD, GAINS_DEFAULT));
    case (s)
      GAINS_DEFAULT: v = GAIN_RESET[idx];
      GAINS_MODEST: begin
        v = {$urandom, $urandom} >> $urandom_range(63, 24);
        if ($urandom_range(1)) v = -v;
      end
      GAINS_EXTREME: begin
        case ($urandom_range(4))
          0: v = GAIN_TOP;
          1: v = GAIN_BOTTOM;
          2: v = '0;
          3: v = '1;
          default: v = GAIN_UNITY;
        endcase
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // mostly values near zero or a running center, keeping the loop out of saturation
  function automatic logic [31:0] draw_sample(input logic [31:0] center);
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = IN_MAX;
          1: v = IN_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2: v = $urandom;
      3, 4, 5: v = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
      default: v = center + ($urandom_range(32'h3FFF) - 32'h2000);
    endcase
    return v;
  endfunction

  // lower both valids and hold until every result word is back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [7:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_GAINS) gain_q[idx[GAIN_IDX_W-1:0]] = val;
  endtask

  task automatic program_gains(input gain_style_t style);
    wait_for_results();
    for (int i = 0; i < NUM_GAINS; i++) write_gain(8'(i), draw_gain(i, style));
    if ($urandom_range(1))
      write_gain(8'($urandom_range(255, NUM_GAINS)), {$urandom, $urandom});
  endtask

  task automatic send_tick(input logic [31:0] fb, input logic [31:0] rf, input logic typed,
                           input logic [127:0] want);
    logic [127:0] predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rf, fb};
    do @(posedge clk); while (!in_tready);
    predicted = advance_observer(fb, rf);
    last_pos = predicted[63:32];
    pending_outputs.push_back(typed ? want : predicted);
  endtask

  initial begin
    logic [31:0] fb, rf;
    gain_style_t style;
    for (int i = 0; i < NUM_GAINS; i++) gain_q[i] = GAIN_RESET[i];
    for (int i = 0; i < 3; i++) est[i] = '0;
    last_pos = '0;
    last_rf = '0;
    fail_count = 0;
    words_checked = 0;
    send_idle_pct = 38;
    recv_idle_pct = 70;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_GAIN) begin
        wait_for_results();
        write_gain(DIRECTED[r].idx, DIRECTED[r].gain);
      end else begin
        send_tick(DIRECTED[r].fb, DIRECTED[r].rf, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase < 4) ? 38 : (phase < 8) ? 70 : 0;
      recv_idle_pct = (phase < 4) ? 70 : (phase < 8) ? 38 : 0;
      case (phase % 4)
        0: style = GAINS_DEFAULT;
        2: style = GAINS_MIXED;
        default: style = GAINS_MODEST;
      endcase
      program_gains(style);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(59) == 0) wait_for_results();
        fb = draw_sample(last_pos);
        rf = draw_sample(last_rf);
        last_rf = rf;
        send_tick(fb, rf, 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_outputs.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word, expected none actual %h", $time, out_tdata);
      end else begin
        want = pending_outputs.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (out_tdata[32*f +: 32] !== want[32*f +: 32]) begin
            fail_count++;
            $display("%0t: word %0d %s expected %h actual %h", $time, words_checked,
                     field_label[f], want[32*f +: 32], out_tdata[32*f +: 32]);
          end
        end
      end
      words_checked++;
    end
  end

  // drop the run if no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
